[src/qlsf_pkg.sv]
// Shared types, constants and solve-step table of the quadratic least-squares fit.
package qlsf_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int CW = 11;
  localparam int XW = 12;
  localparam int YW = 16;
  localparam int TW = 63;
  localparam int OW = 32;
  localparam int WW = 192;
  localparam int BW = 64;
  localparam int QW = 34;
  localparam int STW = 5;
  localparam int MCW = 6;
  localparam int COEF_N = 3;

  localparam logic [TW-1:0] THR_RESET = TW'(4294967);
  localparam logic [STW-1:0] STEP_DET_LAST = STW'(14);
  localparam logic [STW-1:0] STEP_NUM_FIRST = STW'(15);
  localparam logic [STW-1:0] STEP_LAST = STW'(23);
  localparam logic [MCW-1:0] MUL_LAST = MCW'(BW - 1);
  localparam logic [MCW-1:0] DIV_LAST = MCW'(QW - 1);
  localparam logic [1:0] COEF_LAST = 2'(COEF_N - 1);
  localparam logic [1:0] COEF_QUAD = 2'd0;
  localparam logic [1:0] COEF_LIN = 2'd1;
  localparam logic [1:0] COEF_CONST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_CUBE, ST_ACC, ST_MLOAD, ST_MSTEP, ST_MSTORE, ST_CHECK,
    ST_DABS, ST_DPREP, ST_DSTEP, ST_DSTORE, ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    A_S1, A_S2, A_S3, A_S4, A_C00, A_C01, A_C02, A_C11, A_C12, A_C22
  } a_sel_e;

  typedef enum logic [2:0] {
    B_N, B_S1, B_S2, B_S3, B_S4, B_B0, B_B1, B_B2
  } b_sel_e;

  typedef enum logic [3:0] {
    D_NONE, D_C00, D_C01, D_C02, D_C11, D_C12, D_C22, D_DET, D_NA, D_NB, D_NC
  } dest_e;

  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    logic   neg;
    logic   clr;
    dest_e  dest;
  } step_t;

  typedef struct packed {
    logic            in_load;
    logic            sq;
    logic            cube;
    logic            acc;
    logic            mul_load;
    logic            mul_step;
    logic            store;
    logic            check;
    logic            div_abs;
    logic            div_prep;
    logic            div_step;
    logic            div_store;
    logic            out_load;
    logic [STW-1:0]  step;
    logic [1:0]      coef;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic singular;
    logic out_free;
  } sts_t;

  function automatic step_t mk(a_sel_e a, b_sel_e b, logic ng, logic cl, dest_e ds);
    step_t s;
    s.a_sel = a;
    s.b_sel = b;
    s.neg = ng;
    s.clr = cl;
    s.dest = ds;
    return s;
  endfunction

  function automatic step_t step_info(logic [STW-1:0] idx);
    step_t s;
    unique case (idx)
      5'd0:    s = mk(A_S2, B_N, 1'b0, 1'b1, D_NONE);
      5'd1:    s = mk(A_S1, B_S1, 1'b1, 1'b0, D_C00);
      5'd2:    s = mk(A_S1, B_S2, 1'b0, 1'b1, D_NONE);
      5'd3:    s = mk(A_S3, B_N, 1'b1, 1'b0, D_C01);
      5'd4:    s = mk(A_S3, B_S1, 1'b0, 1'b1, D_NONE);
      5'd5:    s = mk(A_S2, B_S2, 1'b1, 1'b0, D_C02);
      5'd6:    s = mk(A_S4, B_N, 1'b0, 1'b1, D_NONE);
      5'd7:    s = mk(A_S2, B_S2, 1'b1, 1'b0, D_C11);
      5'd8:    s = mk(A_S3, B_S2, 1'b0, 1'b1, D_NONE);
      5'd9:    s = mk(A_S4, B_S1, 1'b1, 1'b0, D_C12);
      5'd10:   s = mk(A_S4, B_S2, 1'b0, 1'b1, D_NONE);
      5'd11:   s = mk(A_S3, B_S3, 1'b1, 1'b0, D_C22);
      5'd12:   s = mk(A_C00, B_S4, 1'b0, 1'b1, D_NONE);
      5'd13:   s = mk(A_C01, B_S3, 1'b0, 1'b0, D_NONE);
      5'd14:   s = mk(A_C02, B_S2, 1'b0, 1'b0, D_DET);
      5'd15:   s = mk(A_C00, B_B0, 1'b0, 1'b1, D_NONE);
      5'd16:   s = mk(A_C01, B_B1, 1'b0, 1'b0, D_NONE);
      5'd17:   s = mk(A_C02, B_B2, 1'b0, 1'b0, D_NA);
      5'd18:   s = mk(A_C01, B_B0, 1'b0, 1'b1, D_NONE);
      5'd19:   s = mk(A_C11, B_B1, 1'b0, 1'b0, D_NONE);
      5'd20:   s = mk(A_C12, B_B2, 1'b0, 1'b0, D_NB);
      5'd21:   s = mk(A_C02, B_B0, 1'b0, 1'b1, D_NONE);
      5'd22:   s = mk(A_C12, B_B1, 1'b0, 1'b0, D_NONE);
      5'd23:   s = mk(A_C22, B_B2, 1'b0, 1'b0, D_NC);
      default: s = mk(A_S1, B_N, 1'b0, 1'b0, D_NONE);
    endcase
    return s;
  endfunction

endpackage

[src/quadratic_least_squares_fit_top.sv]
// Top level of the quadratic least-squares fit: sequencer plus datapath.
//
// Input channel (in_valid_i/in_ready_o) takes one (x, y, last) request per
// sample: x signed Q4.8, y signed Q8.8. A sample passes through the registered
// steps accept, square, cube and accumulate before in_ready_o rises again.
// At most 1024 samples are held; later ones are dropped and flagged in
// overflow_o of the next result.
// A request with last_sample_i set starts the solve: 24 products on a
// bit-serial shift-add multiplier (only 15, with no divides, when singular),
// then three 34-step restoring divides. The result
// (coef_quad_o, coef_lin_o, coef_const_o in Q16.16, singular_o, overflow_o)
// is held in an output register under out_valid_o/out_ready_i; sums clear
// as it is loaded. A stalled receiver holds the result; the block takes
// the next set's samples meanwhile, and only a further solve waits.
// cfg_valid_i/cfg_data_i write the determinant threshold (Q31.32) at once;
// write it only while idle. Reset clears all sums, drops the output valid,
// and sets the threshold to 4294967.
module quadratic_least_squares_fit_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [qlsf_pkg::XW-1:0] sample_x_i,
  input  logic signed [qlsf_pkg::YW-1:0] sample_y_i,
  input  logic                           last_sample_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [qlsf_pkg::TW-1:0]        cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [qlsf_pkg::OW-1:0] coef_quad_o,
  output logic signed [qlsf_pkg::OW-1:0] coef_lin_o,
  output logic signed [qlsf_pkg::OW-1:0] coef_const_o,
  output logic                           singular_o,
  output logic                           overflow_o
);

  qlsf_pkg::cmd_t cmd;
  qlsf_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  qlsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qlsf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .last_sample_i (last_sample_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .coef_quad_o   (coef_quad_o),
    .coef_lin_o    (coef_lin_o),
    .coef_const_o  (coef_const_o),
    .singular_o    (singular_o),
    .overflow_o    (overflow_o)
  );

endmodule

[src/qlsf_ctrl.sv]
// Sequencer of the fit: sample pipeline, multiply program, threshold check, divides.
module qlsf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qlsf_pkg::sts_t sts_i,
  output qlsf_pkg::cmd_t cmd_o
);

  qlsf_pkg::state_e state_q, state_d;
  logic [qlsf_pkg::STW-1:0] step_q, step_d;
  logic [qlsf_pkg::MCW-1:0] cnt_q, cnt_d;
  logic [1:0] coef_q, coef_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qlsf_pkg::ST_IDLE;
      step_q <= '0;
      cnt_q <= '0;
      coef_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      cnt_q <= cnt_d;
      coef_q <= coef_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    cnt_d = cnt_q;
    coef_d = coef_q;
    cmd_o = '0;
    cmd_o.step = step_q;
    cmd_o.coef = coef_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      qlsf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = qlsf_pkg::ST_SQ;
        end
      end
      qlsf_pkg::ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d = qlsf_pkg::ST_CUBE;
      end
      qlsf_pkg::ST_CUBE: begin
        cmd_o.cube = 1'b1;
        state_d = qlsf_pkg::ST_ACC;
      end
      qlsf_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.last) begin
          step_d = '0;
          state_d = qlsf_pkg::ST_MLOAD;
        end else begin
          state_d = qlsf_pkg::ST_IDLE;
        end
      end
      qlsf_pkg::ST_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        cnt_d = '0;
        state_d = qlsf_pkg::ST_MSTEP;
      end
      qlsf_pkg::ST_MSTEP: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == qlsf_pkg::MUL_LAST) begin
          state_d = qlsf_pkg::ST_MSTORE;
        end
      end
      qlsf_pkg::ST_MSTORE: begin
        cmd_o.store = 1'b1;
        if (step_q == qlsf_pkg::STEP_DET_LAST) begin
          state_d = qlsf_pkg::ST_CHECK;
        end else if (step_q == qlsf_pkg::STEP_LAST) begin
          coef_d = '0;
          state_d = qlsf_pkg::ST_DABS;
        end else begin
          step_d = step_q + 1'b1;
          state_d = qlsf_pkg::ST_MLOAD;
        end
      end
      qlsf_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.singular) begin
          state_d = qlsf_pkg::ST_FIN;
        end else begin
          step_d = qlsf_pkg::STEP_NUM_FIRST;
          state_d = qlsf_pkg::ST_MLOAD;
        end
      end
      qlsf_pkg::ST_DABS: begin
        cmd_o.div_abs = 1'b1;
        state_d = qlsf_pkg::ST_DPREP;
      end
      qlsf_pkg::ST_DPREP: begin
        cmd_o.div_prep = 1'b1;
        cnt_d = '0;
        state_d = qlsf_pkg::ST_DSTEP;
      end
      qlsf_pkg::ST_DSTEP: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == qlsf_pkg::DIV_LAST) begin
          state_d = qlsf_pkg::ST_DSTORE;
        end
      end
      qlsf_pkg::ST_DSTORE: begin
        cmd_o.div_store = 1'b1;
        if (coef_q == qlsf_pkg::COEF_LAST) begin
          state_d = qlsf_pkg::ST_FIN;
        end else begin
          coef_d = coef_q + 1'b1;
          state_d = qlsf_pkg::ST_DABS;
        end
      end
      qlsf_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = qlsf_pkg::ST_IDLE;
        end
      end
      default: state_d = qlsf_pkg::ST_IDLE;
    endcase
  end

endmodule

[src/qlsf_dp.sv]
// Datapath of the fit: moment sums, shift-add multiplier, divider, output register.
module qlsf_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  qlsf_pkg::cmd_t                 cmd_i,
  output qlsf_pkg::sts_t                 sts_o,
  input  logic signed [qlsf_pkg::XW-1:0] sample_x_i,
  input  logic signed [qlsf_pkg::YW-1:0] sample_y_i,
  input  logic                           last_sample_i,
  input  logic                           cfg_valid_i,
  input  logic [qlsf_pkg::TW-1:0]        cfg_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [qlsf_pkg::OW-1:0] coef_quad_o,
  output logic signed [qlsf_pkg::OW-1:0] coef_lin_o,
  output logic signed [qlsf_pkg::OW-1:0] coef_const_o,
  output logic                           singular_o,
  output logic                           overflow_o
);

  localparam int WW = qlsf_pkg::WW;
  localparam int BW = qlsf_pkg::BW;
  localparam int QW = qlsf_pkg::QW;
  localparam int OW = qlsf_pkg::OW;

  logic signed [11:0] x_q;
  logic signed [15:0] y_q;
  logic last_q;
  logic signed [23:0] x2_q;
  logic signed [27:0] xy_q;
  logic signed [35:0] x3_q;
  logic signed [47:0] x4_q;
  logic signed [39:0] x2y_q;

  logic [qlsf_pkg::CW-1:0] n_q;
  logic signed [23:0] s1_q;
  logic signed [34:0] s2_q;
  logic signed [46:0] s3_q;
  logic signed [57:0] s4_q;
  logic signed [27:0] b2_q;
  logic signed [38:0] b1_q;
  logic signed [50:0] b0_q;
  logic drop_q;
  logic [qlsf_pkg::TW-1:0] thr_q;

  logic signed [WW-1:0] c00_q, c01_q, c02_q, c11_q, c12_q, c22_q, det_q;
  logic signed [WW-1:0] na_q, nb_q, nc_q;
  logic signed [WW-1:0] ma_q, acc_q;
  logic [BW-1:0] mb_q;
  logic [WW-1:0] rem_q, dv_q;
  logic [QW-1:0] q_q;
  logic dneg_q, sing_q;
  logic signed [OW-1:0] cq_q, cl_q, cc_q;
  logic full;

  qlsf_pkg::step_t st;
  logic signed [WW-1:0] a_val, num;
  logic signed [BW-1:0] b_val;
  logic [BW-1:0] b_mag;
  logic b_neg;
  logic [WW-1:0] rem_sh;
  logic signed [OW-1:0] q_res;

  assign st = qlsf_pkg::step_info(cmd_i.step);
  assign full = (n_q == qlsf_pkg::CW'(qlsf_pkg::MAX_SAMPLES));

  always_comb begin
    unique case (st.a_sel)
      qlsf_pkg::A_S1:  a_val = WW'(s1_q);
      qlsf_pkg::A_S2:  a_val = WW'(s2_q);
      qlsf_pkg::A_S3:  a_val = WW'(s3_q);
      qlsf_pkg::A_S4:  a_val = WW'(s4_q);
      qlsf_pkg::A_C00: a_val = c00_q;
      qlsf_pkg::A_C01: a_val = c01_q;
      qlsf_pkg::A_C02: a_val = c02_q;
      qlsf_pkg::A_C11: a_val = c11_q;
      qlsf_pkg::A_C12: a_val = c12_q;
      qlsf_pkg::A_C22: a_val = c22_q;
      default:         a_val = '0;
    endcase
    unique case (st.b_sel)
      qlsf_pkg::B_N:  b_val = signed'(BW'(n_q));
      qlsf_pkg::B_S1: b_val = BW'(s1_q);
      qlsf_pkg::B_S2: b_val = BW'(s2_q);
      qlsf_pkg::B_S3: b_val = BW'(s3_q);
      qlsf_pkg::B_S4: b_val = BW'(s4_q);
      qlsf_pkg::B_B0: b_val = BW'(b0_q);
      qlsf_pkg::B_B1: b_val = BW'(b1_q);
      qlsf_pkg::B_B2: b_val = BW'(b2_q);
      default:        b_val = '0;
    endcase
    b_neg = b_val[BW-1];
    b_mag = b_neg ? BW'(-b_val) : BW'(b_val);
    unique case (cmd_i.coef)
      qlsf_pkg::COEF_QUAD: begin
        num = na_q;
        rem_sh = rem_q << 25;
      end
      qlsf_pkg::COEF_LIN: begin
        num = nb_q;
        rem_sh = rem_q << 17;
      end
      qlsf_pkg::COEF_CONST: begin
        num = nc_q;
        rem_sh = rem_q << 9;
      end
      default: begin
        num = '0;
        rem_sh = '0;
      end
    endcase
    if (!dneg_q) begin
      q_res = (q_q > QW'(34'h7FFFFFFF)) ? OW'(32'h7FFFFFFF) : signed'(q_q[OW-1:0]);
    end else begin
      q_res = (q_q > QW'(34'h80000000)) ? OW'(32'h80000000)
                                         : signed'(OW'(32'd0) - q_q[OW-1:0]);
    end
  end

  assign sts_o.last = last_q;
  assign sts_o.singular = det_q[WW-1] || (det_q == '0) ||
                          (unsigned'(det_q) < (WW'(thr_q) << 16));
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qlsf_pkg::THR_RESET;
      n_q <= '0;
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
      b0_q <= '0;
      b1_q <= '0;
      b2_q <= '0;
      drop_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.acc) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          n_q <= n_q + 1'b1;
          s1_q <= s1_q + 24'(x_q);
          s2_q <= s2_q + 35'(x2_q);
          s3_q <= s3_q + 47'(x3_q);
          s4_q <= s4_q + 58'(x4_q);
          b2_q <= b2_q + 28'(y_q);
          b1_q <= b1_q + 39'(xy_q);
          b0_q <= b0_q + 51'(x2y_q);
        end
      end
      if (cmd_i.out_load) begin
        n_q <= '0;
        s1_q <= '0;
        s2_q <= '0;
        s3_q <= '0;
        s4_q <= '0;
        b0_q <= '0;
        b1_q <= '0;
        b2_q <= '0;
        drop_q <= 1'b0;
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q <= sample_x_i;
      y_q <= sample_y_i;
      last_q <= last_sample_i;
    end
    if (cmd_i.sq) begin
      x2_q <= x_q * x_q;
      xy_q <= x_q * y_q;
    end
    if (cmd_i.cube) begin
      x3_q <= x2_q * x_q;
      x4_q <= x2_q * x2_q;
      x2y_q <= x2_q * y_q;
    end
    if (cmd_i.mul_load) begin
      ma_q <= (st.neg ^ b_neg) ? -a_val : a_val;
      mb_q <= b_mag;
      if (st.clr) begin
        acc_q <= '0;
      end
    end
    if (cmd_i.mul_step) begin
      if (mb_q[0]) begin
        acc_q <= acc_q + ma_q;
      end
      ma_q <= ma_q <<< 1;
      mb_q <= mb_q >> 1;
    end
    if (cmd_i.store) begin
      unique case (st.dest)
        qlsf_pkg::D_C00: c00_q <= acc_q;
        qlsf_pkg::D_C01: c01_q <= acc_q;
        qlsf_pkg::D_C02: c02_q <= acc_q;
        qlsf_pkg::D_C11: c11_q <= acc_q;
        qlsf_pkg::D_C12: c12_q <= acc_q;
        qlsf_pkg::D_C22: c22_q <= acc_q;
        qlsf_pkg::D_DET: det_q <= acc_q;
        qlsf_pkg::D_NA:  na_q <= acc_q;
        qlsf_pkg::D_NB:  nb_q <= acc_q;
        qlsf_pkg::D_NC:  nc_q <= acc_q;
        default: ;
      endcase
    end
    if (cmd_i.check) begin
      sing_q <= sts_o.singular;
    end
    if (cmd_i.div_abs) begin
      rem_q <= num[WW-1] ? unsigned'(-num) : unsigned'(num);
      dneg_q <= num[WW-1];
    end
    if (cmd_i.div_prep) begin
      rem_q <= rem_sh + unsigned'(det_q);
      dv_q <= unsigned'(det_q) << QW;
      q_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dv_q) begin
        rem_q <= rem_q - dv_q;
        q_q <= {q_q[QW-2:0], 1'b1};
      end else begin
        q_q <= {q_q[QW-2:0], 1'b0};
      end
      dv_q <= dv_q >> 1;
    end
    if (cmd_i.div_store) begin
      unique case (cmd_i.coef)
        qlsf_pkg::COEF_QUAD:  cq_q <= q_res;
        qlsf_pkg::COEF_LIN:   cl_q <= q_res;
        qlsf_pkg::COEF_CONST: cc_q <= q_res;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      coef_quad_o <= sing_q ? '0 : cq_q;
      coef_lin_o <= sing_q ? '0 : cl_q;
      coef_const_o <= sing_q ? '0 : cc_q;
      singular_o <= sing_q;
      overflow_o <= drop_q;
    end
  end

endmodule
